/* rtl/core/bta_pkg.sv */
// Shared types and constants for the block table allocator.
// No dependencies; imported by every module of the block.
package bta_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NOMEM   = 2'd1,
        ST_IGNORED = 2'd2
    } t_status;

    // Request type codes carried on the slave tuser.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_HEAP_BASE   = 2'd0;
    localparam logic [1:0] CFG_BLOCK_COUNT = 2'd1;

    // Per-block mark: taken in bit 0, run start in bit 1, has-next in bit 2.
    typedef struct packed {
        logic has_next;
        logic run_first;
        logic taken;
    } t_mark;

    // Decoded request flags from the request decoder to the engine.
    typedef struct packed {
        logic is_free;
        logic reject;
    } t_chk;

endpackage

/* rtl/core/bta_decode.sv */
// Request decoder: block count of an allocation and the block index of a free.
// Depends on bta_pkg.
module bta_decode #(
    parameter int BLOCKS      = 4096,
    parameter int BLOCK_BYTES = 4096
) (
    input  logic                            i_req_type,
    input  logic [31:0]                     i_size,
    input  logic [31:0]                     i_addr,
    input  logic [31:0]                     i_abase,
    input  logic [$clog2(BLOCKS+1)-1:0]     i_total,
    output bta_pkg::t_chk                   o_chk,
    output logic [$clog2(BLOCKS+1)-1:0]     o_need,
    output logic [$clog2(BLOCKS)-1:0]       o_blk
);
    import bta_pkg::*;

    localparam int IW  = $clog2(BLOCKS);
    localparam int CW  = $clog2(BLOCKS + 1);
    localparam int LOG = $clog2(BLOCK_BYTES);
    localparam int NW  = 33 - LOG;
    localparam int BW  = 32 - LOG;

    logic [32:0]   size_up;
    logic [NW-1:0] need_full;
    logic          alloc_bad;
    logic [31:0]   offset;
    logic          free_bad;

    // Round the byte size up to whole blocks.
    assign size_up   = {1'b0, i_size} + 33'(BLOCK_BYTES - 1);
    assign need_full = size_up[32:LOG];
    assign alloc_bad = (need_full == '0) || (need_full > NW'(i_total));

    // Map the address to a block; reject null, low, misaligned and out-of-range.
    assign offset   = i_addr - i_abase;
    assign free_bad = (i_addr == 32'd0) || (i_addr < i_abase)
                   || (offset[LOG-1:0] != '0)
                   || (offset[31:LOG] >= BW'(i_total));

    assign o_chk.is_free = (i_req_type == REQ_FREE);
    assign o_chk.reject  = (i_req_type == REQ_FREE) ? free_bad : alloc_bad;
    assign o_need        = need_full[CW-1:0];
    assign o_blk         = offset[LOG +: IW];

endmodule

/* rtl/core/bta_engine.sv */
// Allocation engine: block mark memory, clearing pass, first-fit scan,
// run marking and run freeing. Depends on bta_pkg.
module bta_engine #(
    parameter int BLOCKS      = 4096,
    parameter int BLOCK_BYTES = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_clear,
    input  logic [$clog2(BLOCKS+1)-1:0]     i_total,
    input  logic [31:0]                     i_abase,
    input  logic                            i_req_valid,
    output logic                            o_req_ready,
    input  bta_pkg::t_chk                   i_chk,
    input  logic [$clog2(BLOCKS+1)-1:0]     i_need,
    input  logic [$clog2(BLOCKS)-1:0]       i_blk,
    output logic                            o_res_valid,
    input  logic                            i_res_ready,
    output logic [31:0]                     o_res_addr,
    output bta_pkg::t_status                o_res_status
);
    import bta_pkg::*;

    localparam int IW  = $clog2(BLOCKS);
    localparam int CW  = $clog2(BLOCKS + 1);
    localparam int LOG = $clog2(BLOCK_BYTES);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_MARK  = 6'b001000,
        S_FREE  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    // Mark memory, one entry per block.
    logic [2:0] mem [BLOCKS];

    t_state  r_state, n_state;
    logic [IW-1:0] r_clr_addr, n_clr_addr;
    logic [CW-1:0] r_hint, n_hint;
    logic          r_chk_vld, n_chk_vld;
    logic          r_first, n_first;
    logic [CW-1:0] r_need, n_need;
    logic [CW-1:0] r_addr, n_addr;
    logic [IW-1:0] r_chk_idx, n_chk_idx;
    logic [CW-1:0] r_run_len, n_run_len;
    logic [IW-1:0] r_seg_start, n_seg_start;
    logic [IW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_left, n_left;
    logic [IW-1:0] r_blk, n_blk;
    logic [31:0]   r_res_addr, n_res_addr;
    t_status       r_res_status, n_res_status;
    t_mark         r_rdata;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_mark         wr_data;
    logic          rd_en;
    logic [IW-1:0] rd_addr;

    logic [CW-1:0] run_len_inc;
    logic [IW-1:0] start_now;
    logic          scan_hit;
    logic [CW-1:0] next_idx;

    assign run_len_inc = r_run_len + 1'b1;
    assign start_now   = (r_run_len == '0) ? r_chk_idx : r_seg_start;
    assign scan_hit    = r_chk_vld && (r_rdata == '0) && (run_len_inc == r_need);
    assign next_idx    = CW'(r_idx) + 1'b1;

    // Sequencer: next state, memory port controls and result.
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_hint       = r_hint;
        n_chk_vld    = r_chk_vld;
        n_first      = r_first;
        n_need       = r_need;
        n_addr       = r_addr;
        n_chk_idx    = r_chk_idx;
        n_run_len    = r_run_len;
        n_seg_start  = r_seg_start;
        n_idx        = r_idx;
        n_left       = r_left;
        n_blk        = r_blk;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        wr_en        = 1'b0;
        wr_addr      = r_idx;
        wr_data      = '0;
        rd_en        = 1'b0;
        rd_addr      = r_idx;

        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_addr;
                n_hint  = '0;
                if (r_clr_addr == IW'(BLOCKS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    if (i_chk.reject) begin
                        n_res_addr   = 32'd0;
                        n_res_status = i_chk.is_free ? ST_IGNORED : ST_NOMEM;
                        n_state      = S_DONE;
                    end else if (i_chk.is_free) begin
                        rd_en   = 1'b1;
                        rd_addr = i_blk;
                        n_idx   = i_blk;
                        n_blk   = i_blk;
                        n_first = 1'b1;
                        n_state = S_FREE;
                    end else begin
                        n_need    = i_need;
                        n_addr    = r_hint;
                        n_chk_vld = 1'b0;
                        n_run_len = '0;
                        n_state   = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Evaluate the entry read last cycle.
                if (r_chk_vld) begin
                    if (r_rdata != '0) begin
                        n_run_len = '0;
                    end else begin
                        n_run_len   = run_len_inc;
                        n_seg_start = start_now;
                    end
                end
                // Stop on a fit, otherwise keep one read in flight.
                if (scan_hit) begin
                    n_chk_vld = 1'b0;
                    n_idx     = start_now;
                    n_left    = r_need;
                    n_state   = S_MARK;
                end else if (r_addr < i_total) begin
                    rd_en     = 1'b1;
                    rd_addr   = r_addr[IW-1:0];
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_addr[IW-1:0];
                    n_addr    = r_addr + 1'b1;
                end else begin
                    n_chk_vld = 1'b0;
                    if (!r_chk_vld) begin
                        n_res_addr   = 32'd0;
                        n_res_status = ST_NOMEM;
                        n_state      = S_DONE;
                    end
                end
            end
            S_MARK: begin
                wr_en             = 1'b1;
                wr_addr           = r_idx;
                wr_data.taken     = 1'b1;
                wr_data.run_first = (r_idx == r_seg_start);
                wr_data.has_next  = (r_left != CW'(1));
                n_idx             = r_idx + 1'b1;
                n_left            = r_left - 1'b1;
                if (r_left == CW'(1)) begin
                    if (CW'(r_seg_start) == r_hint) begin
                        n_hint = CW'(r_seg_start) + r_need;
                    end
                    n_res_addr   = i_abase + (32'(r_seg_start) << LOG);
                    n_res_status = ST_DONE;
                    n_state      = S_DONE;
                end
            end
            S_FREE: begin
                if (r_first && !r_rdata.run_first) begin
                    n_res_addr   = 32'd0;
                    n_res_status = ST_IGNORED;
                    n_state      = S_DONE;
                end else begin
                    // Clear this entry and fetch the next one of the run.
                    wr_en   = 1'b1;
                    wr_addr = r_idx;
                    if (r_rdata.has_next && (next_idx < i_total)) begin
                        rd_en   = 1'b1;
                        rd_addr = next_idx[IW-1:0];
                        n_idx   = next_idx[IW-1:0];
                        n_first = 1'b0;
                    end else begin
                        if (CW'(r_blk) < r_hint) begin
                            n_hint = CW'(r_blk);
                        end
                        n_res_addr   = 32'd0;
                        n_res_status = ST_DONE;
                        n_state      = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase

        // A register write to a known index restarts the clearing pass.
        if (i_cfg_clear) begin
            n_state    = S_CLEAR;
            n_clr_addr = '0;
            n_hint     = '0;
            n_chk_vld  = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_hint     <= '0;
            r_chk_vld  <= 1'b0;
            r_first    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_hint     <= n_hint;
            r_chk_vld  <= n_chk_vld;
            r_first    <= n_first;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_need       <= n_need;
        r_addr       <= n_addr;
        r_chk_idx    <= n_chk_idx;
        r_run_len    <= n_run_len;
        r_seg_start  <= n_seg_start;
        r_idx        <= n_idx;
        r_left       <= n_left;
        r_blk        <= n_blk;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
    end

    // Mark memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= t_mark'(mem[rd_addr]);
        end
    end

    assign o_req_ready  = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_DONE);
    assign o_res_addr   = r_res_addr;
    assign o_res_status = r_res_status;

endmodule

/* rtl/core/block_table_allocator.sv */
// First-fit block table allocator, top level.
// Depends on bta_pkg, bta_decode and bta_engine.
//
// Requests enter on the slave stream: s_tuser selects allocate or free,
// s_tdata carries the byte size and the address. Each request gives exactly
// one result on the master stream: m_tdata is the allocated address (zero on
// failure and for a free), m_tuser the status. Registers are written on the
// cfg channel, which is always ready: index 0 is the heap base, index 1 the
// block count. BLOCK_BYTES must be a power of two.
// One request is in work at a time. An allocation scans the table from the search
// hint, then marks each block of the run; a free clears each block of the run. The
// scan, which reads one mark per cycle from the single-port-read mark memory, sets
// the worst case.
// After reset and after every write to a known register index a clearing pass
// zeroes every entry of the mark memory; s_tready is low for its duration.
// A result waits in an output register while the receiver stalls; the engine
// finishes the next request and holds its result until that register frees.
module block_table_allocator #(
    parameter int BLOCKS      = 4096,
    parameter int BLOCK_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // Request stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] size_bytes, [63:32] address
    input  logic        s_tuser,   // [0] req_type
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] result_address
    output logic [1:0]  m_tuser    // [1:0] status
);
    import bta_pkg::*;

    localparam int IW  = $clog2(BLOCKS);
    localparam int CW  = $clog2(BLOCKS + 1);
    localparam int LOG = $clog2(BLOCK_BYTES);

    logic [31:0] r_heap_base;
    logic [12:0] r_block_count;
    logic        r_m_valid;
    logic [31:0] r_m_addr;
    t_status     r_m_status;

    logic          cfg_wr;
    logic          cfg_clear;
    logic [31:0]   abase;
    logic [CW-1:0] total;
    t_chk          chk;
    logic [CW-1:0] need;
    logic [IW-1:0] blk;
    logic          res_valid;
    logic          res_ready;
    logic [31:0]   res_addr;
    t_status       res_status;

    // Configuration registers; a write to a known index clears the table.
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign cfg_clear   = cfg_wr
                      && ((i_cfg_index == CFG_HEAP_BASE) || (i_cfg_index == CFG_BLOCK_COUNT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base   <= 32'd0;
            r_block_count <= 13'd4096;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_HEAP_BASE:   r_heap_base   <= i_cfg_data;
                CFG_BLOCK_COUNT: r_block_count <= i_cfg_data[12:0];
                default: begin
                end
            endcase
        end
    end

    // Block aligned base and the number of live entries.
    assign abase = {r_heap_base[31:LOG], LOG'(0)};
    assign total = (32'(r_block_count) > 32'(BLOCKS)) ? CW'(BLOCKS) : CW'(r_block_count);

    bta_decode #(
        .BLOCKS      (BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_decode (
        .i_req_type (s_tuser),
        .i_size     (s_tdata[31:0]),
        .i_addr     (s_tdata[63:32]),
        .i_abase    (abase),
        .i_total    (total),
        .o_chk      (chk),
        .o_need     (need),
        .o_blk      (blk)
    );

    bta_engine #(
        .BLOCKS      (BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_clear  (cfg_clear),
        .i_total      (total),
        .i_abase      (abase),
        .i_req_valid  (s_tvalid),
        .o_req_ready  (s_tready),
        .i_chk        (chk),
        .i_need       (need),
        .i_blk        (blk),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res_addr   (res_addr),
        .o_res_status (res_status)
    );

    // Output register between the engine and the result stream.
    assign res_ready = !r_m_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_ready) begin
            r_m_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_m_addr   <= res_addr;
            r_m_status <= res_status;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_addr;
    assign m_tuser  = r_m_status;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the first-fit block table allocator.
// Depends on bta_pkg and block_table_allocator. It keeps its own mark table and
// search hint, predicts every result and checks the result stream against it.
module testbench;
    import bta_pkg::*;

    localparam int BLOCKS      = 4096;
    localparam int BLOCK_BYTES = 4096;

    // Register indexes past the end of the register list; writes to them are no-ops.
    localparam logic [1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [31:0] addr;
        t_status     status;
    } t_alloc_result;

    // Scoreboard: mirrors the mark table, predicts each request's result and
    // checks results in order.
    class heap_tracker;
        t_mark         marks[BLOCKS];
        int unsigned   hint;
        logic [31:0]   heap_base;
        logic [12:0]   block_count;
        t_alloc_result expected_q[$];
        logic [31:0]   live_addrs[$];
        int            errors;
        int            n_alloc_ok;
        int            n_no_mem;
        int            n_free_ok;
        int            n_ignored;

        function new();
            heap_base   = '0;
            block_count = 13'd4096;
            errors      = 0;
            n_alloc_ok  = 0;
            n_no_mem    = 0;
            n_free_ok   = 0;
            n_ignored   = 0;
            clear_table();
        endfunction

        function void clear_table();
            foreach (marks[i]) marks[i] = '0;
            hint = 0;
            live_addrs.delete();
        endfunction

        // A count above the table size uses the whole table.
        function int unsigned live_blocks();
            return (block_count > BLOCKS) ? BLOCKS : int'(block_count);
        endfunction

        function logic [31:0] aligned_base();
            return heap_base & ~32'(BLOCK_BYTES - 1);
        endfunction

        function void apply_register(logic [1:0] idx, logic [31:0] data);
            case (idx)
                CFG_HEAP_BASE: begin
                    heap_base = data;
                    clear_table();
                end
                CFG_BLOCK_COUNT: begin
                    block_count = data[12:0];
                    clear_table();
                end
                default: ;
            endcase
        endfunction

        // First fit from the hint; the hint only advances when the run starts on it.
        function t_alloc_result predict_alloc(logic [31:0] size);
            longint unsigned need;
            int unsigned     total;
            int unsigned     seg_start;
            int unsigned     run_len;
            int unsigned     last_blk;
            bit              found;
            t_alloc_result   r;
            total     = live_blocks();
            need      = (64'(size) + 64'(BLOCK_BYTES - 1)) / 64'(BLOCK_BYTES);
            seg_start = 0;
            run_len   = 0;
            found     = 0;
            r.addr    = '0;
            r.status  = ST_NOMEM;
            if (need == 0 || need > 64'(total)) return r;
            for (int unsigned i = hint; i < total; i++) begin
                if (marks[i] != '0) begin
                    run_len = 0;
                end else begin
                    if (run_len == 0) seg_start = i;
                    run_len++;
                    if (64'(run_len) == need) begin
                        found = 1;
                        break;
                    end
                end
            end
            if (!found) return r;
            last_blk = seg_start + run_len - 1;
            for (int unsigned i = seg_start; i <= last_blk; i++) begin
                marks[i].taken     = 1'b1;
                marks[i].run_first = (i == seg_start);
                marks[i].has_next  = (i != last_blk);
            end
            if (seg_start == hint) hint = seg_start + run_len;
            r.addr   = aligned_base() + 32'(seg_start * BLOCK_BYTES);
            r.status = ST_DONE;
            return r;
        endfunction

        // Clears a run starting at the given address; anything else is ignored.
        function t_alloc_result predict_free(logic [31:0] addr);
            int unsigned   total;
            int unsigned   blk;
            logic [31:0]   base;
            logic [31:0]   off;
            t_mark         m;
            t_alloc_result r;
            total    = live_blocks();
            base     = aligned_base();
            r.addr   = '0;
            r.status = ST_IGNORED;
            if (addr == '0 || addr < base) return r;
            off = addr - base;
            if ((off & 32'(BLOCK_BYTES - 1)) != '0) return r;
            blk = off / 32'(BLOCK_BYTES);
            if (blk >= total) return r;
            if (!marks[blk].run_first) return r;
            for (int unsigned i = blk; i < total; i++) begin
                m        = marks[i];
                marks[i] = '0;
                if (!m.has_next) break;
            end
            if (blk < hint) hint = blk;
            r.status = ST_DONE;
            return r;
        endfunction

        function void note_request(logic req_type, logic [31:0] size, logic [31:0] addr);
            t_alloc_result r;
            int            idx;
            idx = -1;
            if (req_type == REQ_ALLOC) begin
                r = predict_alloc(size);
                if (r.status == ST_DONE) begin
                    n_alloc_ok++;
                    live_addrs.push_back(r.addr);
                end else begin
                    n_no_mem++;
                end
            end else begin
                r = predict_free(addr);
                if (r.status == ST_DONE) begin
                    n_free_ok++;
                    foreach (live_addrs[k]) if (live_addrs[k] == addr) idx = k;
                    if (idx >= 0) live_addrs.delete(idx);
                end else begin
                    n_ignored++;
                end
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [31:0] addr, logic [1:0] status);
            t_alloc_result want;
            if (expected_q.size() == 0) begin
                $error("result with no request pending: result_address %h, status %0d",
                       addr, status);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (addr !== want.addr) begin
                $error("result_address: expected %h, actual %h", want.addr, addr);
                errors++;
            end
            if (status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, status);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;    // [31:0] size_bytes, [63:32] address
    logic        s_tuser;    // [0] req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // [31:0] result_address
    logic [1:0]  m_tuser;    // [1:0] status

    heap_tracker tracker = new();
    bit          quiet_tail = 1'b0;
    bit          gaps_on = 1'b1;

    block_table_allocator #(
        .BLOCKS      (BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Check every result taken by the receiver.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) tracker.check_result(m_tdata, m_tuser);
    end

    // Receiver: stall bursts, long ready stretches, and no stalls in the tail.
    initial begin : result_stall
        m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (quiet_tail) begin
                m_tready <= 1'b1;
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        m_tready <= 1'b0;
                        repeat ($urandom_range(1, 7)) @(posedge i_clk);
                        m_tready <= 1'b1;
                    end
                    1: begin
                        m_tready <= 1'b1;
                        repeat ($urandom_range(20, 80)) @(posedge i_clk);
                    end
                    default: m_tready <= 1'b1;
                endcase
            end
        end
    end

    // Present one request, optionally after an idle burst, and wait for acceptance.
    task automatic send_request(input logic req_type, input logic [31:0] size,
                                input logic [31:0] addr);
        if (!quiet_tail && gaps_on && $urandom_range(0, 2) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req_type;
        s_tdata  <= {addr, size};
        do @(posedge i_clk); while (!s_tready);
        tracker.note_request(req_type, size, addr);
    endtask

    // Stop sending and wait until every predicted result has been seen.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (tracker.expected_q.size() != 0);
    endtask

    // One register write, issued only once the block takes requests again.
    task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
        do @(posedge i_clk); while (!s_tready);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.apply_register(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure_heap(input logic [31:0] base, input logic [31:0] count_word);
        drain_results();
        write_register(CFG_HEAP_BASE, base);
        write_register(CFG_BLOCK_COUNT, count_word);
    endtask

    // Mostly sensible allocations and frees of live runs, with some malformed requests.
    task automatic random_request(input int unsigned max_run);
        int unsigned pick;
        int unsigned blocks;
        int unsigned k;
        logic [31:0] target;
        pick = $urandom_range(0, 99);
        k    = tracker.live_addrs.size();
        if (pick < 45) begin
            blocks = $urandom_range(1, max_run);
            send_request(REQ_ALLOC, 32'((blocks - 1) * BLOCK_BYTES)
                         + 32'($urandom_range(1, BLOCK_BYTES)), $urandom);
        end else if (pick < 85 && k != 0) begin
            send_request(REQ_FREE, $urandom, tracker.live_addrs[$urandom_range(0, k - 1)]);
        end else begin
            target = (k != 0) ? tracker.live_addrs[$urandom_range(0, k - 1)]
                              : tracker.aligned_base();
            case ($urandom_range(0, 4))
                // The block after a run start: inside a run, another run, or free.
                0: send_request(REQ_FREE, $urandom, target + 32'(BLOCK_BYTES));
                1: send_request(REQ_FREE, $urandom,
                                target + 32'($urandom_range(1, BLOCK_BYTES - 1)));
                2: send_request(REQ_FREE, $urandom, $urandom);
                3: send_request(REQ_ALLOC, $urandom, $urandom);
                default: send_request(REQ_ALLOC, 32'd0, $urandom);
            endcase
        end
    endtask

    task automatic random_phase(input logic [31:0] base, input logic [31:0] count_word,
                                input int items, input bit pause_mid, input bit calm_tail);
        int unsigned run_cap;
        configure_heap(base, count_word);
        run_cap = tracker.live_blocks() / 3;
        if (run_cap == 0) run_cap = 1;
        if (run_cap > 8) run_cap = 8;
        for (int n = 0; n < items; n++) begin
            if (n % 10 == 0) gaps_on = ($urandom_range(0, 3) != 0);
            if (calm_tail && n >= items - 20) quiet_tail = 1'b1;
            if (pause_mid && n == items / 2) drain_results();
            random_request(run_cap);
        end
    endtask

    initial begin : stimulus
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_HEAP_BASE;
        i_cfg_data  <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= REQ_ALLOC;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: base 0, full table.
        send_request(REQ_ALLOC, 32'd0, 32'd0);
        send_request(REQ_ALLOC, 32'd1, 32'd0);
        send_request(REQ_ALLOC, 32'd4097, 32'd0);
        send_request(REQ_ALLOC, 32'hFFFF_FFFF, 32'd0);
        send_request(REQ_FREE, 32'd0, 32'd0);
        send_request(REQ_FREE, 32'd0, 32'h0000_2000);
        send_request(REQ_FREE, 32'd0, 32'h0000_1800);
        send_request(REQ_FREE, 32'd0, 32'h0100_0000);
        send_request(REQ_FREE, 32'd0, 32'h0000_1000);
        send_request(REQ_FREE, 32'd0, 32'h0000_1000);
        // A run ending on the last block leaves the hint at the table end.
        send_request(REQ_ALLOC, 32'(4095 * BLOCK_BYTES), 32'd0);
        send_request(REQ_ALLOC, 32'd1, 32'd0);
        send_request(REQ_FREE, 32'd0, 32'h0000_1000);

        // Unaligned base near the top of the address space; addresses wrap to zero.
        configure_heap(32'hFFFF_C123, 32'hABCD_0008);
        send_request(REQ_ALLOC, 32'(4 * BLOCK_BYTES), 32'd0);
        send_request(REQ_ALLOC, 32'd1, 32'd0);
        send_request(REQ_FREE, 32'd0, 32'd0);
        send_request(REQ_FREE, 32'd0, 32'h0000_1000);
        send_request(REQ_ALLOC, 32'(4 * BLOCK_BYTES), 32'd0);
        send_request(REQ_FREE, 32'd0, 32'hFFFF_C000);
        send_request(REQ_ALLOC, 32'(3 * BLOCK_BYTES + 1), 32'd0);

        // Empty table.
        configure_heap(32'hFFFF_C123, 32'd0);
        send_request(REQ_ALLOC, 32'd1, 32'd0);
        send_request(REQ_FREE, 32'd0, 32'hFFFF_C000);

        // Count above the table size, then writes to indexes with no register.
        configure_heap(32'h0000_5000, 32'h0000_1FFF);
        send_request(REQ_ALLOC, 32'd1, 32'd0);
        send_request(REQ_ALLOC, 32'(BLOCKS * BLOCK_BYTES), 32'd0);
        send_request(REQ_FREE, 32'd0, 32'h0100_4000);
        drain_results();
        write_register(CFG_SPARE_2, $urandom);
        write_register(CFG_SPARE_3, 32'hFFFF_FFFF);
        send_request(REQ_ALLOC, 32'd1, 32'd0);

        // Random phases over a spread of heap settings.
        random_phase($urandom, 32'd1, 10, 1'b0, 1'b0);
        random_phase($urandom, 32'($urandom_range(16, 64)), 30, 1'b1, 1'b0);
        random_phase(32'hFFFF_FFFF, ($urandom & 32'hFFFF_E000) | 32'd4096, 12, 1'b0, 1'b0);
        random_phase($urandom, 32'($urandom_range(2, 16)), 30, 1'b0, 1'b0);
        random_phase(32'd0, 32'($urandom_range(8, 32)), 32, 1'b0, 1'b1);

        drain_results();
        repeat (50) @(posedge i_clk);
        $display("Run covered %0d good and %0d out-of-memory allocations, %0d frees and",
                 tracker.n_alloc_ok, tracker.n_no_mem, tracker.n_free_ok);
        $display("%0d ignored frees, with table sizes from empty to full and wrapping bases.",
                 tracker.n_ignored);
        if (tracker.errors == 0 && tracker.expected_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : watchdog
        #100_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
